### design/calculator_token_lexer_assert.svh
// Assertion macros for the lexer modules; clex_queue uses them.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef CALCULATOR_TOKEN_LEXER_ASSERT_SVH
`define CALCULATOR_TOKEN_LEXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLEX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLEX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/clex_pkg.sv
`timescale 1ns / 1ps

package clex_pkg;

	// Width of the line, column and length counters. Result fields are 16 bits.
	localparam int PosBits = 16;
	localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
	localparam int FieldBits = 16;

	// Result queue between the lexing front and the output stage.
	localparam int QueueAw = 2;
	localparam int QueueDepth = 1 << QueueAw;
	localparam int QueueCntW = QueueAw + 1;

	typedef enum logic [1:0] {
		KIND_TOKEN     = 2'd0,
		KIND_BAD_CHAR  = 2'd1,
		KIND_BAD_TOKEN = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		TOK_ADD     = 4'd0,
		TOK_SUB     = 4'd1,
		TOK_MUL     = 4'd2,
		TOK_DIV     = 4'd3,
		TOK_LPAR    = 4'd4,
		TOK_RPAR    = 4'd5,
		TOK_NUMBER  = 4'd6,
		TOK_NAME    = 4'd7,
		TOK_ASSIGN  = 4'd8,
		TOK_NEWLINE = 4'd9
	} tok_t;

	// Raw result as produced by the front. For tokens, pos is the column of
	// the previous character; for errors it is the column of the failing one.
	typedef struct packed {
		kind_t              kind;
		tok_t               token_type;
		logic [PosBits-1:0] line;
		logic [PosBits-1:0] pos;
		logic [PosBits-1:0] len;
		logic               run_end;
	} rec_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
		return (v == PosMax) ? v : v + PosBits'(1);
	endfunction

	function automatic logic [FieldBits-1:0] to_field(input logic [PosBits-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[FieldBits-1:0];
	endfunction

endpackage

### design/clex_in_if.sv
`timescale 1ns / 1ps

interface clex_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

### design/clex_out_if.sv
`timescale 1ns / 1ps

interface clex_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  token_type;
	logic [15:0] line;
	logic [15:0] column;
	logic [15:0] length;
	logic        run_end;

	modport source (output valid, output kind, output token_type, output line,
		output column, output length, output run_end, input ready);
	modport sink (input valid, input kind, input token_type, input line,
		input column, input length, input run_end, output ready);
endinterface

### design/calculator_token_lexer.sv
`timescale 1ns / 1ps

// Calculator token lexer.
// The chars channel takes one character byte per item; byte 0 ends a run.
// The tokens channel gives at most one result item per input item: a token
// (type, one-based start line and column, length) or an error (unacceptable
// character or bad token), with run_end set when the end byte caused it.
// Throughput is one byte per cycle while the result queue is not full. The
// front classifies the byte and steps the lexing automaton and the position
// counters in the cycle it is taken; that state update sets the rate.
// A result passes through the queue and then the output register to tokens.
// A four-item result queue sits between the front and the output register,
// so bytes keep flowing while the receiver stalls; chars.ready drops only
// when the queue is full. After an error, bytes are taken and dropped until
// byte 0. Reset (arst_n low) returns the automaton to its initial state,
// clears the counters and the error halt, and empties the queue and output.
module calculator_token_lexer (
	input  logic       clk,
	input  logic       arst_n,
	clex_in_if.sink    chars,
	clex_out_if.source tokens
);

	logic                push;
	logic                pop;
	clex_pkg::rec_t      push_rec;
	clex_pkg::rec_t      head_rec;
	clex_pkg::q_status_t q_status;

	// Front: classification, automaton and position counters.
	clex_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.q_status (q_status),
		.push     (push),
		.push_rec (push_rec)
	);

	// Queue of raw results that decouples the front from the receiver.
	clex_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.status   (q_status)
	);

	// Back: start column arithmetic, field formatting and the output register.
	clex_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_rec (head_rec),
		.q_status (q_status),
		.pop      (pop),
		.tokens   (tokens)
	);

endmodule

### design/clex_front.sv
`timescale 1ns / 1ps

module clex_front (
	input  logic                  clk,
	input  logic                  arst_n,
	clex_in_if.sink               chars,
	input  clex_pkg::q_status_t   q_status,
	output logic                  push,
	output clex_pkg::rec_t        push_rec
);

	typedef enum logic [3:0] {
		CL_END, CL_SPACE, CL_NL, CL_ADD, CL_SUB, CL_MUL, CL_DIV,
		CL_LP, CL_RP, CL_DIG, CL_PT, CL_LET, CL_ASN, CL_BAD
	} cls_t;

	typedef enum logic [3:0] {
		LX_INIT     = 4'd0,
		LX_ADD      = 4'd1,
		LX_SUB      = 4'd2,
		LX_MUL      = 4'd3,
		LX_DIV      = 4'd4,
		LX_LP       = 4'd5,
		LX_RP       = 4'd6,
		LX_NUM_INT  = 4'd7,
		LX_PT_FRONT = 4'd8,
		LX_PT_AFTER = 4'd9,
		LX_NUM_FRAC = 4'd10,
		LX_NAME     = 4'd11,
		LX_ASN      = 4'd12,
		LX_NL       = 4'd13
	} lex_t;

	localparam logic [7:0] ChEnd   = 8'h00;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChNl    = 8'h0A;
	localparam logic [7:0] ChAdd   = 8'h2B;
	localparam logic [7:0] ChSub   = 8'h2D;
	localparam logic [7:0] ChMul   = 8'h2A;
	localparam logic [7:0] ChDiv   = 8'h2F;
	localparam logic [7:0] ChLp    = 8'h28;
	localparam logic [7:0] ChRp    = 8'h29;
	localparam logic [7:0] ChPt    = 8'h2E;
	localparam logic [7:0] ChAsn   = 8'h3D;
	localparam logic [7:0] ChDig0  = 8'h30;
	localparam logic [7:0] ChDig9  = 8'h39;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowZ  = 8'h7A;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5A;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		case (c)
			ChEnd:   r = CL_END;
			ChSpace: r = CL_SPACE;
			ChNl:    r = CL_NL;
			ChAdd:   r = CL_ADD;
			ChSub:   r = CL_SUB;
			ChMul:   r = CL_MUL;
			ChDiv:   r = CL_DIV;
			ChLp:    r = CL_LP;
			ChRp:    r = CL_RP;
			ChPt:    r = CL_PT;
			ChAsn:   r = CL_ASN;
			default: begin
				if (c >= ChDig0 && c <= ChDig9) begin
					r = CL_DIG;
				end else if ((c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ)) begin
					r = CL_LET;
				end else begin
					r = CL_BAD;
				end
			end
		endcase
		return r;
	endfunction

	// State entered when a byte starts a new token.
	function automatic lex_t start_of(input cls_t cl);
		lex_t r;
		case (cl)
			CL_NL:   r = LX_NL;
			CL_ADD:  r = LX_ADD;
			CL_SUB:  r = LX_SUB;
			CL_MUL:  r = LX_MUL;
			CL_DIV:  r = LX_DIV;
			CL_LP:   r = LX_LP;
			CL_RP:   r = LX_RP;
			CL_DIG:  r = LX_NUM_INT;
			CL_PT:   r = LX_PT_FRONT;
			CL_LET:  r = LX_NAME;
			CL_ASN:  r = LX_ASN;
			default: r = LX_INIT;
		endcase
		return r;
	endfunction

	lex_t               state_q;
	logic [clex_pkg::PosBits-1:0] line_q, col_q, pline_q, pcol_q, tlen_q;
	logic               halt_q;

	cls_t               cls;
	lex_t               boundary, mv_next;
	logic               mv_tok, mv_bad, is_end, accept;
	clex_pkg::tok_t     mv_type;
	logic [clex_pkg::PosBits-1:0] tlen_kept;

	assign chars.ready = !q_status.full;
	assign accept      = chars.valid && chars.ready;
	assign cls         = classify(chars.char_byte);
	assign is_end      = (cls == CL_END);
	assign boundary    = start_of(cls);

	// One automaton move.
	always_comb begin
		mv_next = boundary;
		mv_tok  = 1'b0;
		mv_bad  = 1'b0;
		mv_type = clex_pkg::TOK_ADD;
		case (state_q)
			LX_NUM_INT: begin
				if (cls == CL_DIG) begin
					mv_next = LX_NUM_INT;
				end else if (cls == CL_PT) begin
					mv_next = LX_PT_AFTER;
				end else if (cls == CL_LET) begin
					mv_bad = 1'b1;
				end else begin
					mv_tok  = 1'b1;
					mv_type = clex_pkg::TOK_NUMBER;
				end
			end
			LX_PT_FRONT: begin
				if (cls == CL_DIG) begin
					mv_next = LX_NUM_INT;
				end else begin
					mv_bad = 1'b1;
				end
			end
			LX_PT_AFTER, LX_NUM_FRAC: begin
				if (cls == CL_DIG) begin
					mv_next = LX_NUM_FRAC;
				end else if (cls == CL_PT || cls == CL_LET) begin
					mv_bad = 1'b1;
				end else begin
					mv_tok  = 1'b1;
					mv_type = clex_pkg::TOK_NUMBER;
				end
			end
			LX_NAME: begin
				if (cls == CL_DIG || cls == CL_LET) begin
					mv_next = LX_NAME;
				end else if (cls == CL_PT) begin
					mv_bad = 1'b1;
				end else begin
					mv_tok  = 1'b1;
					mv_type = clex_pkg::TOK_NAME;
				end
			end
			LX_ADD: begin
				mv_tok  = 1'b1;
				mv_type = clex_pkg::TOK_ADD;
			end
			LX_SUB: begin
				mv_tok  = 1'b1;
				mv_type = clex_pkg::TOK_SUB;
			end
			LX_MUL: begin
				mv_tok  = 1'b1;
				mv_type = clex_pkg::TOK_MUL;
			end
			LX_DIV: begin
				mv_tok  = 1'b1;
				mv_type = clex_pkg::TOK_DIV;
			end
			LX_LP: begin
				mv_tok  = 1'b1;
				mv_type = clex_pkg::TOK_LPAR;
			end
			LX_RP: begin
				mv_tok  = 1'b1;
				mv_type = clex_pkg::TOK_RPAR;
			end
			LX_ASN: begin
				mv_tok  = 1'b1;
				mv_type = clex_pkg::TOK_ASSIGN;
			end
			LX_NL: begin
				mv_tok  = 1'b1;
				mv_type = clex_pkg::TOK_NEWLINE;
			end
			default: begin
				mv_next = boundary;
			end
		endcase
	end

	// Result record for this byte, if any.
	always_comb begin
		push              = 1'b0;
		push_rec.kind       = clex_pkg::KIND_TOKEN;
		push_rec.token_type = clex_pkg::TOK_ADD;
		push_rec.line       = clex_pkg::sat_inc(line_q);
		push_rec.pos        = col_q;
		push_rec.len        = '0;
		push_rec.run_end    = is_end;
		if (accept && !halt_q) begin
			if (cls == CL_BAD) begin
				push          = 1'b1;
				push_rec.kind = clex_pkg::KIND_BAD_CHAR;
			end else if (mv_bad) begin
				push          = 1'b1;
				push_rec.kind = clex_pkg::KIND_BAD_TOKEN;
			end else if (mv_tok) begin
				push                = 1'b1;
				push_rec.token_type = mv_type;
				push_rec.line       = clex_pkg::sat_inc(pline_q);
				push_rec.pos        = pcol_q;
				push_rec.len        = tlen_q;
			end
		end
	end

	assign tlen_kept = mv_tok ? '0 : tlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LX_INIT;
			line_q  <= '0;
			col_q   <= '0;
			pline_q <= '0;
			pcol_q  <= '0;
			tlen_q  <= '0;
			halt_q  <= 1'b0;
		end else if (accept) begin
			if (is_end) begin
				// The end byte returns everything to the reset values.
				state_q <= LX_INIT;
				line_q  <= '0;
				col_q   <= '0;
				pline_q <= '0;
				pcol_q  <= '0;
				tlen_q  <= '0;
				halt_q  <= 1'b0;
			end else if (halt_q) begin
				halt_q <= 1'b1;
			end else if (cls == CL_BAD || mv_bad) begin
				halt_q <= 1'b1;
			end else begin
				state_q <= mv_next;
				pline_q <= line_q;
				pcol_q  <= col_q;
				tlen_q  <= (cls == CL_SPACE) ? tlen_kept : clex_pkg::sat_inc(tlen_kept);
				if (mv_next == LX_NL) begin
					line_q <= clex_pkg::sat_inc(line_q);
					col_q  <= '0;
				end else begin
					col_q <= clex_pkg::sat_inc(col_q);
				end
			end
		end
	end

endmodule

### design/clex_queue.sv
`timescale 1ns / 1ps

`include "calculator_token_lexer_assert.svh"

module clex_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  clex_pkg::rec_t      push_rec,
	input  logic                pop,
	output clex_pkg::rec_t      head_rec,
	output clex_pkg::q_status_t status
);

	clex_pkg::rec_t entries_q [clex_pkg::QueueDepth];
	logic [clex_pkg::QueueAw-1:0]   wr_ptr_q, rd_ptr_q;
	logic [clex_pkg::QueueCntW-1:0] count_q;

	assign head_rec         = entries_q[rd_ptr_q];
	assign status.full      = (count_q == clex_pkg::QueueCntW'(clex_pkg::QueueDepth));
	assign status.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CLEX_ASSERT_NOW(a_push_not_full, push, !status.full, "result queue written while full")
	`CLEX_ASSERT_NOW(a_pop_not_empty, pop, status.not_empty, "result queue read while empty")
	`CLEX_ASSERT_NOW(a_count_bound, 1'b1, count_q <= clex_pkg::QueueCntW'(clex_pkg::QueueDepth), "result queue count out of range")
	`CLEX_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "result queue count did not grow")

endmodule

### design/clex_back.sv
`timescale 1ns / 1ps

module clex_back (
	input  logic                clk,
	input  logic                arst_n,
	input  clex_pkg::rec_t      head_rec,
	input  clex_pkg::q_status_t q_status,
	output logic                pop,
	clex_out_if.source          tokens
);

	logic                           valid_q;
	logic [1:0]                     kind_q;
	logic [3:0]                     type_q;
	logic [15:0]                    line_q, column_q, length_q;
	logic                           run_end_q;

	logic [clex_pkg::PosBits:0]     col_plus2, col_diff;
	logic [clex_pkg::PosBits-1:0]   column;

	// A token starts length characters before the one after the previous byte.
	always_comb begin
		col_plus2 = {1'b0, head_rec.pos} + (clex_pkg::PosBits + 1)'(2);
		if (col_plus2 > {1'b0, head_rec.len}) begin
			col_diff = col_plus2 - {1'b0, head_rec.len};
		end else begin
			col_diff = (clex_pkg::PosBits + 1)'(1);
		end
		if (head_rec.kind != clex_pkg::KIND_TOKEN) begin
			column = clex_pkg::sat_inc(head_rec.pos);
		end else if (col_diff > {1'b0, clex_pkg::PosMax}) begin
			column = clex_pkg::PosMax;
		end else begin
			column = col_diff[clex_pkg::PosBits-1:0];
		end
	end

	assign pop = q_status.not_empty && (!valid_q || tokens.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (tokens.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= head_rec.kind;
			type_q    <= head_rec.token_type;
			line_q    <= clex_pkg::to_field(head_rec.line);
			column_q  <= clex_pkg::to_field(column);
			length_q  <= clex_pkg::to_field(head_rec.len);
			run_end_q <= head_rec.run_end;
		end
	end

	assign tokens.valid      = valid_q;
	assign tokens.kind       = kind_q;
	assign tokens.token_type = type_q;
	assign tokens.line       = line_q;
	assign tokens.column     = column_q;
	assign tokens.length     = length_q;
	assign tokens.run_end    = run_end_q;

endmodule

### tb/tb_calculator_token_lexer.sv
`timescale 1ns / 1ps

// Self-checking bench for the calculator token lexer.
// Each character item accepted on the chars channel is run through a local copy of
// the lexing automaton, and the token or error it closes is queued. Every result item
// on the tokens channel is checked against the oldest queued token, field by field.
module tb_calculator_token_lexer;
	import clex_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam logic [15:0] POS_TOP = 16'hFFFF;

	// Character classes, in the order the automaton indexes them.
	typedef enum logic [3:0] {
		CLS_END, CLS_SPACE, CLS_NEWLINE, CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV,
		CLS_LPAR, CLS_RPAR, CLS_DIGIT, CLS_POINT, CLS_LETTER, CLS_ASSIGN, CLS_BAD
	} char_class_t;

	// Automaton states. The six operator states and the assign and newline states
	// each hold a one-character token that the next byte closes.
	typedef enum logic [3:0] {
		ST_IDLE, ST_ADD, ST_SUB, ST_MUL, ST_DIV, ST_LPAR, ST_RPAR, ST_INT,
		ST_LEAD_POINT, ST_TRAIL_POINT, ST_FRAC, ST_NAME, ST_ASSIGN, ST_NEWLINE
	} lex_state_t;

	typedef enum logic [1:0] {ACT_NONE, ACT_TOKEN, ACT_BAD} close_t;

	// Directed rows either use the predictor or carry a typed-in outcome.
	typedef enum logic {ROW_PREDICT, ROW_FIXED} row_mode_t;

	// Malformed pieces that the random runs splice in.
	typedef enum logic [2:0] {
		FLAW_NOISE, FLAW_NUM_LETTER, FLAW_NAME_POINT, FLAW_DOUBLE_POINT, FLAW_LONE_POINT
	} flaw_t;

	typedef struct packed {
		kind_t       kind;
		tok_t        token_type;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] length;
		logic        run_end;
	} lex_result_t;

	typedef struct {
		logic [7:0]  ch;
		row_mode_t   mode;
		bit          hit;
		lex_result_t fixed;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	clex_in_if  chars_if ();
	clex_out_if tokens_if ();

	calculator_token_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: automaton, zero-based position of the next byte, position of
	// the previous byte, running token length, and the halt after an error.
	lex_state_t  scan_state;
	logic [15:0] line_pos;
	logic [15:0] col_pos;
	logic [15:0] last_line;
	logic [15:0] last_col;
	logic [15:0] tok_len;
	bit          halted;

	lex_result_t pending_tokens[$];
	table_row_t  directed_rows[$];
	logic [7:0]  run_text[$];

	// Side information that travels with the byte currently driven.
	row_mode_t   row_mode;
	bit          row_hit;
	lex_result_t row_fixed;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned lexed_items;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	string       op_chars = "+-*/()=";

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == POS_TOP) ? v : v + 16'd1;
	endfunction

	function automatic lex_result_t make_result(input kind_t k, input tok_t t,
			input logic [15:0] ln, input logic [15:0] col, input logic [15:0] len,
			input logic fin);
		lex_result_t r;
		r.kind = k;
		r.token_type = t;
		r.line = ln;
		r.column = col;
		r.length = len;
		r.run_end = fin;
		return r;
	endfunction

	function automatic string fmt_result(input lex_result_t r);
		return $sformatf("kind %0d type %0d line %0d column %0d length %0d end %0d",
			r.kind, r.token_type, r.line, r.column, r.length, r.run_end);
	endfunction

	function automatic void clear_lexer();
		scan_state = ST_IDLE;
		line_pos = '0;
		col_pos = '0;
		last_line = '0;
		last_col = '0;
		tok_len = '0;
		halted = 1'b0;
	endfunction

	function automatic char_class_t classify_char(input logic [7:0] ch);
		case (ch)
			8'h00: return CLS_END;
			" ": return CLS_SPACE;
			"\n": return CLS_NEWLINE;
			"+": return CLS_ADD;
			"-": return CLS_SUB;
			"*": return CLS_MUL;
			"/": return CLS_DIV;
			"(": return CLS_LPAR;
			")": return CLS_RPAR;
			".": return CLS_POINT;
			"=": return CLS_ASSIGN;
			default: begin
				if (ch >= "0" && ch <= "9")
					return CLS_DIGIT;
				if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))
					return CLS_LETTER;
				return CLS_BAD;
			end
		endcase
	endfunction

	// State entered when a byte starts a new token.
	function automatic lex_state_t entry_state(input char_class_t cls);
		case (cls)
			CLS_NEWLINE: return ST_NEWLINE;
			CLS_ADD: return ST_ADD;
			CLS_SUB: return ST_SUB;
			CLS_MUL: return ST_MUL;
			CLS_DIV: return ST_DIV;
			CLS_LPAR: return ST_LPAR;
			CLS_RPAR: return ST_RPAR;
			CLS_DIGIT: return ST_INT;
			CLS_POINT: return ST_LEAD_POINT;
			CLS_LETTER: return ST_NAME;
			CLS_ASSIGN: return ST_ASSIGN;
			default: return ST_IDLE;
		endcase
	endfunction

	function automatic tok_t single_token(input lex_state_t st);
		case (st)
			ST_ADD: return TOK_ADD;
			ST_SUB: return TOK_SUB;
			ST_MUL: return TOK_MUL;
			ST_DIV: return TOK_DIV;
			ST_LPAR: return TOK_LPAR;
			ST_RPAR: return TOK_RPAR;
			ST_ASSIGN: return TOK_ASSIGN;
			default: return TOK_NEWLINE;
		endcase
	endfunction

	// One automaton move. A closed token leaves the byte to start the next one.
	function automatic void lex_move(input lex_state_t st, input char_class_t cls,
			output lex_state_t nxt, output close_t act, output tok_t tok);
		nxt = entry_state(cls);
		act = ACT_NONE;
		tok = TOK_ADD;
		case (st)
			ST_INT: begin
				if (cls == CLS_DIGIT) begin
					nxt = ST_INT;
				end else if (cls == CLS_POINT) begin
					nxt = ST_TRAIL_POINT;
				end else if (cls == CLS_LETTER) begin
					act = ACT_BAD;
					nxt = ST_IDLE;
				end else begin
					act = ACT_TOKEN;
					tok = TOK_NUMBER;
				end
			end
			ST_LEAD_POINT: begin
				if (cls == CLS_DIGIT) begin
					nxt = ST_INT;
				end else begin
					act = ACT_BAD;
					nxt = ST_IDLE;
				end
			end
			ST_TRAIL_POINT, ST_FRAC: begin
				if (cls == CLS_DIGIT) begin
					nxt = ST_FRAC;
				end else if (cls == CLS_POINT || cls == CLS_LETTER) begin
					act = ACT_BAD;
					nxt = ST_IDLE;
				end else begin
					act = ACT_TOKEN;
					tok = TOK_NUMBER;
				end
			end
			ST_NAME: begin
				if (cls == CLS_DIGIT || cls == CLS_LETTER) begin
					nxt = ST_NAME;
				end else if (cls == CLS_POINT) begin
					act = ACT_BAD;
					nxt = ST_IDLE;
				end else begin
					act = ACT_TOKEN;
					tok = TOK_NAME;
				end
			end
			ST_ADD, ST_SUB, ST_MUL, ST_DIV, ST_LPAR, ST_RPAR, ST_ASSIGN, ST_NEWLINE: begin
				act = ACT_TOKEN;
				tok = single_token(st);
			end
			default: ;
		endcase
	endfunction

	// Works out the result item, if any, that one accepted character causes.
	function automatic void predict_token(input logic [7:0] ch, output bit produced,
			output lex_result_t res);
		char_class_t cls;
		lex_state_t  nxt;
		close_t      act;
		tok_t        tok;
		bit          at_end;
		int unsigned col;
		cls = classify_char(ch);
		at_end = (cls == CLS_END);
		produced = 1'b0;
		res = '0;
		if (halted) begin
			if (at_end)
				clear_lexer();
			return;
		end
		lexed_items++;
		// An unacceptable byte is caught before the automaton sees it.
		if (cls == CLS_BAD) begin
			res = make_result(KIND_BAD_CHAR, TOK_ADD, bump(line_pos), bump(col_pos),
				16'd0, 1'b0);
			produced = 1'b1;
			halted = 1'b1;
			return;
		end
		lex_move(scan_state, cls, nxt, act, tok);
		if (act == ACT_BAD) begin
			res = make_result(KIND_BAD_TOKEN, TOK_ADD, bump(line_pos), bump(col_pos),
				16'd0, at_end);
			produced = 1'b1;
			if (at_end)
				clear_lexer();
			else
				halted = 1'b1;
			return;
		end
		if (act == ACT_TOKEN) begin
			// Start column is worked back from the last byte of the token.
			col = int'(last_col) + 2;
			col = (col > tok_len) ? col - tok_len : 1;
			if (col > POS_TOP)
				col = POS_TOP;
			res = make_result(KIND_TOKEN, tok, bump(last_line), 16'(col), tok_len, at_end);
			produced = 1'b1;
			tok_len = '0;
		end
		if (at_end) begin
			clear_lexer();
			return;
		end
		if (cls != CLS_SPACE)
			tok_len = bump(tok_len);
		scan_state = nxt;
		last_line = line_pos;
		last_col = col_pos;
		col_pos = bump(col_pos);
		if (nxt == ST_NEWLINE) begin
			line_pos = bump(line_pos);
			col_pos = '0;
		end
	endfunction

	function automatic void report_bad(input string what, input bit has_want,
			input lex_result_t want, input lex_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			if (has_want)
				$display("%s: expected %s, got %s", what, fmt_result(want), fmt_result(got));
			else
				$display("%s: nothing expected, got %s", what, fmt_result(got));
		end
	endfunction

	// Both handshakes are sampled at the rising edge. The input side is handled first
	// so that a token caused by this byte is already queued when its result shows up.
	always @(posedge clk) begin
		bit          produced;
		lex_result_t res;
		lex_result_t want;
		lex_result_t got;
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready) begin
				predict_token(chars_if.char_byte, produced, res);
				if (row_mode == ROW_FIXED) begin
					produced = row_hit;
					res = row_fixed;
				end
				if (produced)
					pending_tokens.insert(pending_tokens.size(), res);
			end
			if (tokens_if.valid && tokens_if.ready) begin
				got = make_result(kind_t'(tokens_if.kind), tok_t'(tokens_if.token_type),
					tokens_if.line, tokens_if.column, tokens_if.length, tokens_if.run_end);
				if (pending_tokens.size() == 0) begin
					report_bad("unexpected result item", 1'b0, '0, got);
				end else begin
					want = pending_tokens.pop_front();
					if (got.kind !== want.kind || got.token_type !== want.token_type ||
							got.line !== want.line || got.column !== want.column ||
							got.length !== want.length || got.run_end !== want.run_end)
						report_bad("result mismatch", 1'b1, want, got);
				end
			end
		end
	end

	// The receiver stalls at random; the rate is changed from phase to phase.
	always @(negedge clk)
		tokens_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("calculator_token_lexer regression: fail");
			$finish;
		end
	end

	// Offers one character item, with random idle cycles in front of it, and returns
	// at the rising edge that accepts it.
	task automatic feed_char(input logic [7:0] ch, input row_mode_t mode, input bit hit,
			input lex_result_t fixed);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_byte <= ch;
		row_mode <= mode;
		row_hit <= hit;
		row_fixed <= fixed;
		do
			@(posedge clk);
		while (!chars_if.ready);
	endtask

	task automatic feed_run();
		foreach (run_text[i])
			feed_char(run_text[i], ROW_PREDICT, 1'b0, '0);
	endtask

	// Holds the sender off until every queued token has come back.
	task automatic drain_results();
		@(negedge clk);
		chars_if.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	function automatic void table_row(input logic [7:0] ch, input row_mode_t mode,
			input bit hit, input lex_result_t fixed);
		table_row_t r;
		r.ch = ch;
		r.mode = mode;
		r.hit = hit;
		r.fixed = fixed;
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	// Adds one byte to the end of the run being built.
	function automatic void append_char(input logic [7:0] ch);
		run_text.insert(run_text.size(), ch);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	// Integer part, optional fraction with zero or more digits, or a leading point.
	function automatic void add_number();
		if ($urandom_range(0, 99) < 15) begin
			append_char(".");
			repeat ($urandom_range(1, 3))
				append_char(rand_digit());
		end else begin
			repeat ($urandom_range(1, 4))
				append_char(rand_digit());
			if ($urandom_range(0, 99) < 40) begin
				append_char(".");
				repeat ($urandom_range(0, 3))
					append_char(rand_digit());
			end
		end
	endfunction

	// Mostly short names, now and then a long one.
	function automatic void add_name();
		int unsigned tail;
		tail = ($urandom_range(0, 99) < 5) ? $urandom_range(20, 60) : $urandom_range(0, 6);
		append_char(rand_letter());
		repeat (tail)
			append_char(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
	endfunction

	function automatic void add_flaw();
		append_char(" ");
		case (flaw_t'($urandom_range(0, 4)))
			FLAW_NOISE: append_char(8'($urandom_range(1, 255)));
			FLAW_NUM_LETTER: begin
				append_char(rand_digit());
				append_char(rand_letter());
			end
			FLAW_NAME_POINT: begin
				append_char(rand_letter());
				append_char(".");
			end
			FLAW_DOUBLE_POINT: begin
				append_char(rand_digit());
				append_char(".");
				append_char(rand_digit());
				append_char(".");
			end
			default: append_char(".");
		endcase
	endfunction

	// One run of text ending in byte 0. Most runs are well-formed expressions; a few
	// are empty, pure noise, or carry one malformed piece (possibly just before the end).
	function automatic void build_run();
		int unsigned n_tokens;
		int unsigned flaw_at;
		int unsigned pick;
		bit          was_word;
		bit          word;
		run_text.delete();
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			// Empty run: byte 0 alone.
		end else if (pick < 10) begin
			repeat ($urandom_range(1, 8))
				append_char(8'($urandom_range(1, 255)));
		end else begin
			n_tokens = $urandom_range(1, 14);
			flaw_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n_tokens) : n_tokens + 1;
			was_word = 1'b0;
			for (int i = 0; i < n_tokens; i++) begin
				if (i == flaw_at)
					add_flaw();
				pick = $urandom_range(0, 9);
				word = (pick < 6);
				// Two words need a space between them or they would merge.
				repeat ($urandom_range((word && was_word) ? 1 : 0, 2))
					append_char(" ");
				if (pick < 3)
					add_number();
				else if (pick < 6)
					add_name();
				else
					append_char(op_chars[$urandom_range(0, 6)]);
				if ($urandom_range(0, 99) < 12) begin
					append_char("\n");
					was_word = 1'b0;
				end else begin
					was_word = word;
				end
			end
			if (flaw_at == n_tokens)
				add_flaw();
			else if ($urandom_range(0, 9) == 0)
				append_char(($urandom_range(0, 1)) ? 8'h20 : 8'h0A);
		end
		append_char(8'h00);
	endfunction

	task automatic random_phase(input int unsigned target);
		int unsigned start;
		start = lexed_items;
		while (lexed_items - start < target) begin
			build_run();
			feed_run();
			if ($urandom_range(0, 9) == 0)
				drain_results();
		end
	endtask

	initial begin
		string sample;
		chars_if.valid = 1'b0;
		chars_if.char_byte = 8'h00;
		tokens_if.ready = 1'b0;
		row_mode = ROW_PREDICT;
		row_hit = 1'b0;
		row_fixed = '0;
		send_idle_pct = 25;
		recv_stall_pct = 87;
		lexed_items = 0;
		mismatch_count = 0;
		cycle_count = 0;
		clear_lexer();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items. An empty run right after reset gives nothing. An unacceptable
		// byte at the very start is reported at line 1, column 1, and the byte after it
		// is dropped. A lone point cut off by the end byte is a bad token that carries
		// run_end. The expression then uses every token type, with the newline token
		// closed by the end byte.
		table_row(8'h00, ROW_FIXED, 1'b0, '0);
		table_row(8'hFF, ROW_FIXED, 1'b1,
			make_result(KIND_BAD_CHAR, TOK_ADD, 16'd1, 16'd1, 16'd0, 1'b0));
		table_row("z", ROW_FIXED, 1'b0, '0);
		table_row(8'h00, ROW_FIXED, 1'b0, '0);
		table_row(".", ROW_FIXED, 1'b0, '0);
		table_row(8'h00, ROW_FIXED, 1'b1,
			make_result(KIND_BAD_TOKEN, TOK_ADD, 16'd1, 16'd2, 16'd0, 1'b1));
		sample = "ab =(1.5-.2)*3/c+9\n";
		for (int i = 0; i < sample.len(); i++)
			table_row(sample[i], ROW_PREDICT, 1'b0, '0);
		table_row(8'h00, ROW_PREDICT, 1'b0, '0);
		foreach (directed_rows[i])
			feed_char(directed_rows[i].ch, directed_rows[i].mode, directed_rows[i].hit,
				directed_rows[i].fixed);
		drain_results();

		// Slow receiver.
		random_phase(220);
		drain_results();

		// Slow sender.
		send_idle_pct = 87;
		recv_stall_pct = 25;
		random_phase(220);
		drain_results();

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(210);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("calculator_token_lexer regression: pass");
		else
			$display("calculator_token_lexer regression: fail");
		$finish;
	end

endmodule
